// ===== design/bfom_pkg.sv =====
// ----------------------------------------------------------------------------
// bfom_pkg
// Shared types, action codes and character constants for the byte FIFO
// with overflow marker.
// ----------------------------------------------------------------------------
package bfom_pkg;

    // Input action codes.
    localparam logic [1:0] ACT_RAW = 2'd0;
    localparam logic [1:0] ACT_HEX = 2'd1;
    localparam logic [1:0] ACT_POP = 2'd2;

    // Characters and nibble constants.
    localparam logic [7:0] MARK_CHAR = 8'h40;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_A    = 8'h41;
    localparam logic [3:0] NIB_TEN   = 4'hA;

    // Width of the reported fill level.
    localparam int FILL_W = 6;

    typedef enum logic [1:0] {
        CMD_NOP,
        CMD_RAW,
        CMD_HEX,
        CMD_POP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  data;
        logic        eom;
    } cmd_t;

    // Uppercase ASCII hex digit of one nibble.
    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] result;
        if (nib < NIB_TEN)
        begin
            result = CHAR_ZERO + {4'h0, nib};
        end
        else
        begin
            result = CHAR_A + {4'h0, nib - NIB_TEN};
        end
        return result;
    endfunction

endpackage

// ===== design/bfom_front.sv =====
// ----------------------------------------------------------------------------
// bfom_front
// Accepts input items, decodes the action into a command and holds up to
// two commands in a small queue for the back end.
// ----------------------------------------------------------------------------
module bfom_front
    import bfom_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [7:0]  data_byte,
    input  logic        end_of_message,
    output logic        cmd_valid,
    output cmd_t        cmd,
    input  logic        cmd_take
);

    cmd_t        slot_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic        push;
    logic        pop;
    cmd_t        decoded;

    always_comb
    begin
        decoded.data = data_byte;
        decoded.eom  = 1'b0;
        unique case (action)
            ACT_RAW:
            begin
                decoded.kind = CMD_RAW;
                decoded.eom  = end_of_message;
            end
            ACT_HEX:
            begin
                decoded.kind = CMD_HEX;
                decoded.eom  = end_of_message;
            end
            ACT_POP:
            begin
                decoded.kind = CMD_POP;
            end
            default:
            begin
                decoded.kind = CMD_NOP;
            end
        endcase
    end

    assign in_stall  = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign push      = in_valid && !in_stall;
    assign pop       = cmd_take && cmd_valid;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

// ===== design/bfom_back.sv =====
// ----------------------------------------------------------------------------
// bfom_back
// Executes commands against the circular byte store: pushes, hex pushes,
// overflow marking and pops, and holds one result for the output channel.
// ----------------------------------------------------------------------------
module bfom_back
    import bfom_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  cmd_t               cmd,
    output logic               cmd_take,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               tx_valid,
    output logic [7:0]         tx_byte,
    output logic               overflow_hit,
    output logic               fifo_empty,
    output logic [FILL_W-1:0]  fill_level
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_WRITE2 = 4'b0010,
        ST_MARK2  = 4'b0100,
        ST_READ   = 4'b1000
    } state_t;

    function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
        return (i == LAST) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [AW-1:0] idx_back(input logic [AW-1:0] i);
        return (i == '0) ? LAST : i - 1'b1;
    endfunction

    logic [7:0]        mem [DEPTH];
    logic [7:0]        rd_data_reg;

    state_t            state_reg;
    state_t            state_next;
    logic [AW-1:0]     wi_reg;
    logic [AW-1:0]     wi_next;
    logic [AW-1:0]     ri_reg;
    logic [AW-1:0]     ri_next;
    logic [AW-1:0]     cnt_reg;
    logic [AW-1:0]     cnt_next;
    logic              disc_reg;
    logic              disc_next;
    logic              eom_reg;
    logic              eom_next;
    logic [AW-1:0]     mark_reg;
    logic [AW-1:0]     mark_next;
    logic [7:0]        lo_reg;
    logic [7:0]        lo_next;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;

    logic              out_valid_reg;
    logic              tx_valid_reg;
    logic [7:0]        tx_byte_reg;
    logic              ovf_reg;
    logic              empty_reg;
    logic [FILL_W-1:0] fill_reg;

    logic              out_take;
    logic              out_free;
    logic              full;
    logic              res_load;
    logic              res_txv;
    logic [7:0]        res_byte;
    logic              res_ovf;
    logic [7:0]        push_char;
    logic [AW+FILL_W-1:0] cnt_ext;

    assign out_take = out_valid_reg && !out_stall;
    assign out_free = !out_valid_reg || out_take;
    assign full     = (cnt_reg == LAST);

    always_comb
    begin
        state_next = state_reg;
        wi_next    = wi_reg;
        ri_next    = ri_reg;
        cnt_next   = cnt_reg;
        disc_next  = disc_reg;
        eom_next   = eom_reg;
        mark_next  = mark_reg;
        lo_next    = lo_reg;
        wr_en      = 1'b0;
        wr_addr    = wi_reg;
        wr_data    = MARK_CHAR;
        rd_en      = 1'b0;
        rd_addr    = ri_reg;
        cmd_take   = 1'b0;
        res_load   = 1'b0;
        res_txv    = 1'b0;
        res_byte   = 8'h00;
        res_ovf    = 1'b0;
        push_char  = (cmd.kind == CMD_HEX) ? hex_digit(cmd.data[7:4]) : cmd.data;

        unique case (state_reg)
            ST_IDLE:
            begin
                // A command starts only when the result slot is free, so the
                // slot stays free until this command completes.
                if (cmd_valid && out_free)
                begin
                    cmd_take = 1'b1;
                    eom_next = cmd.eom;
                    case (cmd.kind)
                        CMD_POP:
                        begin
                            if (cnt_reg != '0)
                            begin
                                rd_en      = 1'b1;
                                ri_next    = idx_inc(ri_reg);
                                cnt_next   = cnt_reg - 1'b1;
                                state_next = ST_READ;
                            end
                            else
                            begin
                                res_load = 1'b1;
                            end
                        end
                        CMD_RAW, CMD_HEX:
                        begin
                            if (disc_reg)
                            begin
                                disc_next = !cmd.eom;
                                res_load  = 1'b1;
                            end
                            else if (full)
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = idx_back(wi_reg);
                                mark_next  = idx_back(wi_reg);
                                state_next = ST_MARK2;
                            end
                            else
                            begin
                                wr_en    = 1'b1;
                                wr_data  = push_char;
                                wi_next  = idx_inc(wi_reg);
                                cnt_next = cnt_reg + 1'b1;
                                if (cmd.kind == CMD_HEX)
                                begin
                                    lo_next    = hex_digit(cmd.data[3:0]);
                                    state_next = ST_WRITE2;
                                end
                                else
                                begin
                                    res_load = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_WRITE2:
            begin
                if (full)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = idx_back(wi_reg);
                    mark_next  = idx_back(wi_reg);
                    state_next = ST_MARK2;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_data    = lo_reg;
                    wi_next    = idx_inc(wi_reg);
                    cnt_next   = cnt_reg + 1'b1;
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_MARK2:
            begin
                wr_en      = 1'b1;
                wr_addr    = idx_back(mark_reg);
                disc_next  = !eom_reg;
                res_ovf    = 1'b1;
                res_load   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_READ:
            begin
                res_txv    = 1'b1;
                res_byte   = rd_data_reg;
                res_load   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign cnt_ext = {{FILL_W{1'b0}}, cnt_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wi_reg        <= '0;
            ri_reg        <= '0;
            cnt_reg       <= '0;
            disc_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wi_reg    <= wi_next;
            ri_reg    <= ri_next;
            cnt_reg   <= cnt_next;
            disc_reg  <= disc_next;
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        eom_reg  <= eom_next;
        mark_reg <= mark_next;
        lo_reg   <= lo_next;
        if (res_load)
        begin
            tx_valid_reg <= res_txv;
            tx_byte_reg  <= res_byte;
            ovf_reg      <= res_ovf;
            empty_reg    <= (cnt_next == '0);
            fill_reg     <= cnt_ext[FILL_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign out_valid    = out_valid_reg;
    assign tx_valid     = tx_valid_reg;
    assign tx_byte      = tx_byte_reg;
    assign overflow_hit = ovf_reg;
    assign fifo_empty   = empty_reg;
    assign fill_level   = fill_reg;

endmodule

// ===== design/byte_fifo_with_overflow_marker.sv =====
// ----------------------------------------------------------------------------
// byte_fifo_with_overflow_marker
// Circular transmit byte FIFO with raw and hex pushes, sink pops and an
// overflow marker of two '@' characters.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  input    in_valid / in_stall  action, data_byte, end_of_message
//  output   out_valid/out_stall  tx_valid, tx_byte, overflow_hit,
//                                fifo_empty, fill_level
//
// Each item gives one result. Raw pushes, dropped pushes, empty pops and the
// unused action end in ST_IDLE; pops add ST_READ, hex pushes ST_WRITE2 and
// overflows ST_MARK2, and a hex push overflowing on its low digit adds both
// (one store write port). The two-entry queue registers commands for the back end.
// Reset clears pointers, count and discard mode; the store is not cleared.
// A stalled output holds its result and the back end waits before the next one.
// ----------------------------------------------------------------------------
module byte_fifo_with_overflow_marker
    import bfom_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         action,
    input  logic [7:0]         data_byte,
    input  logic               end_of_message,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               tx_valid,
    output logic [7:0]         tx_byte,
    output logic               overflow_hit,
    output logic               fifo_empty,
    output logic [FILL_W-1:0]  fill_level
);

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_take;

    bfom_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .cmd_take       (cmd_take)
    );

    bfom_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_take     (cmd_take),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .tx_valid     (tx_valid),
        .tx_byte      (tx_byte),
        .overflow_hit (overflow_hit),
        .fifo_empty   (fifo_empty),
        .fill_level   (fill_level)
    );

endmodule
